@@ rtl/core/bdil_pkg.sv @@
// Shared types, register codes and constants for the 3x3 binary dilation core.
package bdil_pkg;

	localparam int CFG_W   = 10;
	localparam int MASK_W  = 9;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int WIN_N   = 9;
	localparam int CENTER  = 4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MASK   = 2'd2;

	localparam logic [CFG_W-1:0]  RST_WIDTH  = CFG_W'(512);
	localparam logic [CFG_W-1:0]  RST_HEIGHT = CFG_W'(512);
	localparam logic [MASK_W-1:0] RST_MASK   = MASK_W'(511);

	localparam logic [CHAN_W-1:0] WHITE      = 8'hFF;
	localparam logic              KIND_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [CFG_W-1:0]  width;
		logic [CFG_W-1:0]  height;
		logic [MASK_W-1:0] mask;
		logic              restart;
	} cfg_t;

endpackage

@@ rtl/core/bdil_cfg.sv @@
// Configuration register file with APB-style access and size clamping.
module bdil_cfg import bdil_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [MASK_W-1:0] mask_q;
	logic              wr;
	logic [1:0]        idx;
	logic [CFG_W-1:0]  eff_w;
	logic [CFG_W-1:0]  eff_h;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			mask_q   <= RST_MASK;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_MASK:   mask_q   <= pwdata[MASK_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		eff_w = width_q;
		if (width_q == '0) begin
			eff_w = CFG_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = CFG_W'(MAX_WIDTH);
		end
		eff_h = height_q;
		if (height_q == '0) begin
			eff_h = CFG_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			eff_h = CFG_W'(MAX_HEIGHT);
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_MASK:   prdata = PDATA_W'(mask_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.width   = eff_w;
	assign cfg.height  = eff_h;
	assign cfg.mask    = mask_q;
	assign cfg.restart = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);

endmodule

@@ rtl/core/bdil_line_buf.sv @@
// Two-row line memory: read on accept, write back when the pixel advances, with bypass.
module bdil_line_buf import bdil_pkg::*; #(
	parameter int MAX_WIDTH = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] width,
	input  logic             restart,
	input  logic             acc,
	input  logic             adv,
	input  pixel_t           pix_s1,
	output pixel_t           up1,
	output pixel_t           up2
);

	localparam int XW    = ($clog2(MAX_WIDTH) < CFG_W) ? $clog2(MAX_WIDTH) : CFG_W;
	localparam int DEPTH = (MAX_WIDTH < (1 << CFG_W)) ? MAX_WIDTH : (1 << CFG_W) - 1;

	logic [2*PIX_W-1:0] mem [DEPTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] fwd_q;
	logic [2*PIX_W-1:0] rdv;
	logic [2*PIX_W-1:0] wdata;
	logic               byp_q;
	logic [XW-1:0]      col_q;
	logic [XW-1:0]      addr_s1;
	logic               col_end;

	assign col_end = ({1'b0, CFG_W'(col_q)} + (CFG_W + 1)'(1)) == {1'b0, width};

	assign rdv   = byp_q ? fwd_q : rd_q;
	assign up1   = rdv[PIX_W-1:0];
	assign up2   = rdv[2*PIX_W-1:PIX_W];
	assign wdata = {up1, pix_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			mem[addr_s1] <= wdata;
		end
		if (acc) begin
			rd_q  <= mem[col_q];
			fwd_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			addr_s1 <= '0;
			byp_q   <= 1'b0;
		end else begin
			if (restart) begin
				col_q <= '0;
			end else if (acc) begin
				col_q <= col_end ? '0 : col_q + XW'(1);
			end
			if (acc) begin
				addr_s1 <= col_q;
				byp_q   <= adv && (addr_s1 == col_q);
			end
		end
	end

endmodule

@@ rtl/core/bdil_window.sv @@
// 3x3 window registers, frame position tracking and the dilation decision.
module bdil_window import bdil_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   adv,
	input  pixel_t pix_s1,
	input  pixel_t up1,
	input  pixel_t up2,
	output logic   res_valid,
	output pixel_t res_pix,
	output logic   res_last
);

	localparam int XW = ($clog2(MAX_WIDTH) < CFG_W) ? $clog2(MAX_WIDTH) : CFG_W;
	localparam int YW = ($clog2(MAX_HEIGHT) < CFG_W) ? $clog2(MAX_HEIGHT) : CFG_W;

	pixel_t           win_q [WIN_N];
	pixel_t           nw    [WIN_N];
	logic [CFG_W-1:0] warm_q;
	logic             primed_q;
	logic [XW-1:0]    ocol_q;
	logic [YW-1:0]    orow_q;
	logic             col_end;
	logic             row_end;
	logic             interior;
	logic             hit;

	assign col_end = ({1'b0, CFG_W'(ocol_q)} + (CFG_W + 1)'(1)) == {1'b0, cfg.width};
	assign row_end = ({1'b0, CFG_W'(orow_q)} + (CFG_W + 1)'(1)) == {1'b0, cfg.height};
	assign interior = (ocol_q != '0) && !col_end && (orow_q != '0) && !row_end;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nw[3*r]     = win_q[3*r+1];
			nw[3*r + 1] = win_q[3*r+2];
		end
		nw[2] = up2;
		nw[5] = up1;
		nw[8] = pix_s1;
		hit = 1'b0;
		for (int k = 0; k < WIN_N; k++) begin
			if (cfg.mask[k] && (nw[k][CHAN_W-1:0] == WHITE)) begin
				hit = 1'b1;
			end
		end
	end

	assign res_valid = adv && primed_q;
	assign res_pix   = (interior && hit) ? '1 : nw[CENTER];
	assign res_last  = row_end && col_end;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < WIN_N; k++) begin
				win_q[k] <= nw[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q   <= '0;
			primed_q <= 1'b0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (cfg.restart) begin
			warm_q   <= '0;
			primed_q <= 1'b0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (adv) begin
			if (!primed_q) begin
				if (warm_q == cfg.width) begin
					primed_q <= 1'b1;
				end else begin
					warm_q <= warm_q + CFG_W'(1);
				end
			end else if (res_last) begin
				warm_q   <= '0;
				primed_q <= 1'b0;
				ocol_q   <= '0;
				orow_q   <= '0;
			end else if (col_end) begin
				ocol_q <= '0;
				orow_q <= orow_q + YW'(1);
			end else begin
				ocol_q <= ocol_q + XW'(1);
			end
		end
	end

endmodule

@@ rtl/core/binary_dilation_3x3_core.sv @@
// Top level of the streaming 3x3 binary dilation core.
// Pixels enter in raster order on the s_ channel and each one leaves on the m_ channel
// width+1 transactions later. The core sustains one transaction per clock while
// m_tready holds: a two-row line memory of MAX_WIDTH entries is read once per
// accepted pixel and written back as it advances, with a bypass when both hit the
// same entry. An interior pixel turns white (all channels 255) when any neighbor
// selected by the structuring mask has channel A at 255; border pixels pass as they
// are. After the last pixel of a frame, send width+1 more transactions (tuser set
// for a flush) to push out the rest; tlast marks the frame's last pixel. Writing the
// width or height register restarts the frame. No clearing pass follows reset.
module binary_dilation_3x3_core import bdil_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [PIX_W-1:0]   s_tdata,  // chan_a_in [7:0], chan_b_in [15:8], chan_c_in [23:16]
	input  logic               s_tuser,  // kind
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [PIX_W-1:0]   m_tdata,  // chan_a_out [7:0], chan_b_out [15:8], chan_c_out [23:16]
	output logic               m_tlast,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t   cfg;
	logic   acc;
	logic   adv;
	logic   valid_s1;
	pixel_t pix_s1;
	pixel_t up1;
	pixel_t up2;
	logic   res_valid;
	pixel_t res_pix;
	logic   res_last;
	logic   out_valid_q;
	pixel_t out_pix_q;
	logic   out_last_q;

	assign pready   = 1'b1;
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	bdil_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bdil_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.width   (cfg.width),
		.restart (cfg.restart),
		.acc     (acc),
		.adv     (adv),
		.pix_s1  (pix_s1),
		.up1     (up1),
		.up2     (up2)
	);

	bdil_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.adv       (adv),
		.pix_s1    (pix_s1),
		.up1       (up1),
		.up2       (up2),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_last  (res_last)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= (s_tuser == KIND_FLUSH) ? '0 : s_tdata;
		end
		if (adv && res_valid) begin
			out_pix_q  <= res_pix;
			out_last_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/core/bdil_checker.sv @@
// Port-level checker for the dilation core, bound to the top level.
module bdil_checker import bdil_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [PIX_W-1:0]   m_tdata,
	input logic               m_tlast,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	input logic               pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output side is ready");

	a_rd_upper: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[PDATA_W-1:CFG_W] == '0)
		else $error("register read returns bits above the field");

	a_mask_rb: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_MASK)
		&& psel && !pwrite && paddr[PADDR_W-1:2] == REG_MASK
		|-> prdata[MASK_W-1:0] == $past(pwdata[MASK_W-1:0]))
		else $error("mask readback differs from last write");

endmodule

bind binary_dilation_3x3_core bdil_checker u_chk (.*);

@@ tb/binary_dilation_3x3_checker.sv @@
// 3x3 binary dilation checker: predicts and compares every output pixel and register read.
`timescale 1ns / 1ps
module binary_dilation_3x3_checker import bdil_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [PIX_W-1:0]   s_tdata,  // chan_a_in [7:0], chan_b_in [15:8], chan_c_in [23:16]
	input  logic               s_tuser,  // kind
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [PIX_W-1:0]   m_tdata,  // chan_a_out [7:0], chan_b_out [15:8], chan_c_out [23:16]
	input  logic               m_tlast,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending
);
	localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		pixel_t pix;
		logic   frame_end;
	} out_pixel_t;

	pixel_t            line_mem [LINE_DEPTH];
	int                line_pos;
	int                items_seen;
	int                out_col;
	int                out_row;
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	logic [MASK_W-1:0] mask_reg;
	out_pixel_t        dilated_pixels [$];
	out_pixel_t        oldest;

	function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic pixel_t line_tap(int back);
		return line_mem[(line_pos + LINE_DEPTH - back % LINE_DEPTH) % LINE_DEPTH];
	endfunction

	function automatic void restart_frame();
		items_seen = 0;
		out_col    = 0;
		out_row    = 0;
	endfunction

	function automatic void report(string what);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s", $time, what);
	endfunction

	function automatic void dilate_item(logic kind, pixel_t data);
		int     w;
		int     h;
		pixel_t result;
		pixel_t nb;
		logic   last;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		line_pos = (line_pos + 1) % LINE_DEPTH;
		line_mem[line_pos] = (kind == KIND_FLUSH) ? '0 : data;
		if (items_seen < w + 1) begin
			items_seen++;
			return;
		end
		result = line_tap(w + 1);
		if (out_col != 0 && out_col + 1 != w && out_row != 0 && out_row + 1 != h) begin
			for (int k = 0; k < WIN_N; k++) begin
				nb = line_tap((2 - k / 3) * w + (2 - k % 3));
				if (mask_reg[k] && nb[CHAN_W-1:0] == WHITE)
					result = '1;
			end
		end
		last = (out_row + 1 == h) && (out_col + 1 == w);
		dilated_pixels.push_back(out_pixel_t'{pix: result, frame_end: last});
		if (last) begin
			restart_frame();
		end else begin
			items_seen++;
			if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		end
	endfunction

	function automatic void apply_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		case (addr[PADDR_W-1:2])
			REG_WIDTH: begin
				width_reg = data[CFG_W-1:0];
				restart_frame();
			end
			REG_HEIGHT: begin
				height_reg = data[CFG_W-1:0];
				restart_frame();
			end
			REG_MASK: begin
				mask_reg = data[MASK_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_read(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] want;
		case (addr[PADDR_W-1:2])
			REG_WIDTH:  want = PDATA_W'(width_reg);
			REG_HEIGHT: want = PDATA_W'(height_reg);
			REG_MASK:   want = PDATA_W'(mask_reg);
			default:    return;
		endcase
		if (data !== want)
			report($sformatf("register at %0d read: expected %0d, got %0d", addr, want, data));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_DEPTH; i++)
				line_mem[i] = '0;
			line_pos   = 0;
			width_reg  = RST_WIDTH;
			height_reg = RST_HEIGHT;
			mask_reg   = RST_MASK;
			restart_frame();
			dilated_pixels.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite)
					apply_write(paddr, pwdata);
				else
					check_read(paddr, prdata);
			end
			if (s_tvalid && s_tready)
				dilate_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (dilated_pixels.size() == 0) begin
					report($sformatf("unexpected pixel a=%0d b=%0d c=%0d last=%0b",
						m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast));
				end else begin
					oldest = dilated_pixels.pop_front();
					if (m_tdata !== oldest.pix || m_tlast !== oldest.frame_end)
						report($sformatf({"pixel: expected a=%0d b=%0d c=%0d last=%0b, ",
							"got a=%0d b=%0d c=%0d last=%0b"},
							oldest.pix[7:0], oldest.pix[15:8], oldest.pix[23:16],
							oldest.frame_end, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
							m_tlast));
				end
			end
			pending = dilated_pixels.size();
		end
	end

endmodule

@@ tb/binary_dilation_3x3_core_tb.sv @@
// Testbench top for the 3x3 binary dilation core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module binary_dilation_3x3_core_tb import bdil_pkg::*;;

	localparam int         MAX_WIDTH    = 512;
	localparam int         MAX_HEIGHT   = 512;
	localparam int         RESET_CYCLES = 11;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         PHASE_ITEMS  = 310;
	localparam int         WIDE_EXTRA   = 12;
	localparam int         FULL_FRAME   = 1 << 30;
	localparam logic [1:0] REG_UNUSED   = 2'd3;
	localparam logic       KIND_PIXEL   = ~KIND_FLUSH;

	typedef struct packed {
		logic              kind;
		logic [CHAN_W-1:0] chan_c;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_a;
	} pixel_item_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [PIX_W-1:0]   s_tdata  = '0;
	logic               s_tuser  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [PIX_W-1:0]   m_tdata;
	logic               m_tlast;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [PDATA_W-1:0] pwdata   = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;
	int                 tx_idle_pct = 21;
	int                 rx_idle_pct = 69;
	int                 items_sent  = 0;
	int                 stall_count = 0;
	int                 phase_start;

	binary_dilation_3x3_core #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	binary_dilation_3x3_checker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic int fit(int v, int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic pixel_item_t make_item(logic kind, int a, int b, int c);
		pixel_item_t item;
		item.kind   = kind;
		item.chan_a = CHAN_W'(a);
		item.chan_b = CHAN_W'(b);
		item.chan_c = CHAN_W'(c);
		return item;
	endfunction

	function automatic pixel_item_t random_item(int flush_pct, int white_pct);
		return make_item(($urandom_range(99) < flush_pct) ? KIND_FLUSH : KIND_PIXEL,
			($urandom_range(99) < white_pct) ? int'(WHITE) : $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
	endfunction

	function automatic int pick_mask();
		case ($urandom_range(5))
			0:       return 48;
			1:       return 144;
			2:       return 511;
			3:       return 186;
			4:       return 0;
			default: return $urandom_range(511);
		endcase
	endfunction

	task automatic send_item(pixel_item_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= item.kind;
		s_tdata  <= {item.chan_c, item.chan_b, item.chan_a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_frame(int cols, int rows, int limit);
		int body;
		int total;
		int white_pct;
		body      = cols * rows;
		total     = body + cols + 1;
		white_pct = $urandom_range(50);
		if (limit < total)
			total = limit;
		for (int i = 0; i < total; i++)
			send_item(random_item((i < body) ? 6 : 80, white_pct));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_access(logic write, logic [1:0] index, int data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= PADDR_W'({index, 2'b00});
		pwdata  <= PDATA_W'(data);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] index, int data);
		reg_access(1'b1, index, data);
		if (index != REG_UNUSED)
			reg_access(1'b0, index, 0);
	endtask

	task automatic configure(int w_val, int h_val, int mask_val);
		settle();
		set_reg(REG_WIDTH, w_val);
		set_reg(REG_HEIGHT, h_val);
		set_reg(REG_MASK, mask_val);
	endtask

	task automatic run_segment();
		int   choice;
		int   w_val;
		int   h_val;
		int   cols;
		int   rows;
		int   frames;
		int   limit;
		logic broken;
		choice = $urandom_range(99);
		w_val  = $urandom_range(3, 8);
		h_val  = $urandom_range(3, 6);
		frames = $urandom_range(1, 3);
		limit  = FULL_FRAME;
		broken = 1'b0;
		if (choice < 12) begin
			if ($urandom_range(1))
				w_val = $urandom_range(1, 2);
			else
				h_val = $urandom_range(1, 2);
		end else if (choice < 18) begin
			if ($urandom_range(1))
				w_val = 0;
			else
				h_val = 0;
		end else if (choice < 24) begin
			w_val  = $urandom_range(1, 4);
			h_val  = $urandom_range(512, 1023);
			frames = 1;
			limit  = $urandom_range(w_val + 2, 40);
		end else if (choice < 34) begin
			frames = $urandom_range(1, 2);
			broken = 1'b1;
		end
		cols = fit(w_val, MAX_WIDTH);
		rows = fit(h_val, MAX_HEIGHT);
		if (broken)
			limit = $urandom_range(1, cols * rows + cols);
		configure(w_val, h_val, pick_mask());
		for (int f = 0; f < frames; f++)
			send_frame(cols, rows, (f == frames - 1) ? limit : FULL_FRAME);
		if (choice >= 94) begin
			settle();
			set_reg(REG_UNUSED, $urandom);
			set_reg(REG_MASK, pick_mask());
			send_frame(cols, rows, FULL_FRAME);
		end
	endtask

	initial begin
		while (stall_count < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				stall_count = 0;
			else
				stall_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		reg_access(1'b0, REG_WIDTH, 0);
		reg_access(1'b0, REG_HEIGHT, 0);
		reg_access(1'b0, REG_MASK, 0);

		configure(4, 3, 511);
		send_item(make_item(KIND_PIXEL, 255, 0, 0));
		send_item(make_item(KIND_PIXEL, 0, 255, 255));
		send_item(make_item(KIND_PIXEL, 254, 127, 128));
		send_item(make_item(KIND_PIXEL, 1, 2, 3));
		send_item(make_item(KIND_PIXEL, 0, 0, 0));
		send_item(make_item(KIND_PIXEL, 128, 64, 32));
		send_item(make_item(KIND_FLUSH, 255, 255, 255));
		send_item(make_item(KIND_PIXEL, 255, 255, 255));
		send_item(make_item(KIND_PIXEL, 0, 0, 0));
		send_item(make_item(KIND_PIXEL, 0, 0, 0));
		send_item(make_item(KIND_PIXEL, 255, 0, 0));
		send_item(make_item(KIND_PIXEL, 17, 34, 51));
		send_item(make_item(KIND_FLUSH, 0, 0, 0));
		send_item(make_item(KIND_PIXEL, 255, 255, 255));
		send_item(make_item(KIND_FLUSH, 255, 0, 0));
		send_item(make_item(KIND_PIXEL, 255, 0, 0));
		send_item(make_item(KIND_FLUSH, 0, 0, 0));

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 21 : ((phase == 1) ? 69 : 0);
			rx_idle_pct = (phase == 0) ? 69 : ((phase == 1) ? 21 : 0);
			if (phase == 2) begin
				configure($urandom_range(1) ? MAX_WIDTH : 1023, 3, 186);
				send_frame(MAX_WIDTH, 3, MAX_WIDTH + 1 + WIDE_EXTRA);
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				run_segment();
		end

		settle();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
